// File: hdl/binary_heap_priority_queue_unit_defines.svh
// Assertion macros for the heap queue.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define BHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define BHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/bhpq_pkg.sv
`timescale 1ns / 1ps

package bhpq_pkg;

    localparam int KEY_MAX_BITS = 32;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic latch;
        logic set_empty;
        logic set_full;
        logic push_init;
        logic pop_init;
        logic pop_load;
        logic up_read;
        logic up_move;
        logic dn_read;
        logic dn_move;
        logic place;
        logic top_read;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_pop;
        logic count_zero;
        logic full;
        logic idx_zero;
        logic up_beats;
        logic dn_stop;
    } t_dp_stat;

    // strict priority compare: a wins over b
    function automatic logic beats(input logic order_max,
                                   input logic [KEY_MAX_BITS-1:0] a,
                                   input logic [KEY_MAX_BITS-1:0] b);
        return order_max ? (a > b) : (a < b);
    endfunction

endpackage

// File: hdl/bhpq_if.sv
`timescale 1ns / 1ps

interface bhpq_in_if #(
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;

    modport source (output valid, command, key, payload, input ready);
    modport sink   (input valid, command, key, payload, output ready);
endinterface

interface bhpq_out_if #(
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16,
    parameter int COUNT_BITS   = 11
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     popped_key;
    logic [PAYLOAD_BITS-1:0] popped_payload;
    logic                    top_valid;
    logic [KEY_BITS-1:0]     top_key;
    logic [PAYLOAD_BITS-1:0] top_payload;
    logic [COUNT_BITS-1:0]   entry_count;

    modport source (output valid, status, popped_key, popped_payload, top_valid,
                    top_key, top_payload, entry_count, input ready);
    modport sink   (input valid, status, popped_key, popped_payload, top_valid,
                    top_key, top_payload, entry_count, output ready);
endinterface

interface bhpq_cfg_if;
    logic valid;
    logic ready;
    logic order_max;

    modport source (output valid, order_max, input ready);
    modport sink   (input valid, order_max, output ready);
endinterface

// File: hdl/bhpq_ctrl.sv
`timescale 1ns / 1ps

module bhpq_ctrl
    import bhpq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_UP_RD    = 4'd2;
    localparam logic [3:0] S_UP_EV    = 4'd3;
    localparam logic [3:0] S_POP_LD   = 4'd4;
    localparam logic [3:0] S_DN_RD    = 4'd5;
    localparam logic [3:0] S_DN_EV    = 4'd6;
    localparam logic [3:0] S_PLACE    = 4'd7;
    localparam logic [3:0] S_RES_RD   = 4'd8;
    localparam logic [3:0] S_RES_LD   = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.is_pop) begin
                    if (i_stat.count_zero) begin
                        o_cmd.set_empty = 1'b1;
                        n_state         = S_RES_RD;
                    end else begin
                        o_cmd.pop_init = 1'b1;
                        n_state        = S_POP_LD;
                    end
                end else begin
                    if (i_stat.full) begin
                        o_cmd.set_full = 1'b1;
                        n_state        = S_RES_RD;
                    end else begin
                        o_cmd.push_init = 1'b1;
                        n_state         = S_UP_RD;
                    end
                end
            end
            S_UP_RD: begin
                if (i_stat.idx_zero) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = S_UP_EV;
                end
            end
            S_UP_EV: begin
                if (i_stat.up_beats) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = S_UP_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_POP_LD: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd.dn_read = 1'b1;
                n_state       = S_DN_EV;
            end
            S_DN_EV: begin
                if (i_stat.dn_stop) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = S_DN_RD;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_RES_RD;
            end
            S_RES_RD: begin
                o_cmd.top_read = 1'b1;
                n_state        = S_RES_LD;
            end
            S_RES_LD: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/bhpq_dp.sv
`timescale 1ns / 1ps

module bhpq_dp
    import bhpq_pkg::*;
#(
    parameter int CAPACITY     = 1024,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_dp_cmd                            i_cmd,
    output t_dp_stat                           o_stat,
    input  logic                               i_in_command,
    input  logic [KEY_BITS-1:0]                i_in_key,
    input  logic [PAYLOAD_BITS-1:0]            i_in_payload,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_order_max,
    output logic [1:0]                         o_status,
    output logic [KEY_BITS-1:0]                o_popped_key,
    output logic [PAYLOAD_BITS-1:0]            o_popped_payload,
    output logic                               o_top_valid,
    output logic [KEY_BITS-1:0]                o_top_key,
    output logic [PAYLOAD_BITS-1:0]            o_top_payload,
    output logic [$clog2(CAPACITY+1)-1:0]      o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int CW = AW + 2;
    localparam int EW = KEY_BITS + PAYLOAD_BITS;

    logic [EW-1:0]           r_mem [CAPACITY];
    logic [EW-1:0]           r_rd_a, r_rd_b;
    logic                    r_order;
    logic [NW-1:0]           r_count;
    logic                    r_is_pop;
    logic [KEY_BITS-1:0]     r_x_key;
    logic [PAYLOAD_BITS-1:0] r_x_pay;
    logic [AW-1:0]           r_idx;
    logic [1:0]              r_status;
    logic [KEY_BITS-1:0]     r_pop_key;
    logic [PAYLOAD_BITS-1:0] r_pop_pay;

    logic [1:0]              r_res_status;
    logic [KEY_BITS-1:0]     r_res_pop_key;
    logic [PAYLOAD_BITS-1:0] r_res_pop_pay;
    logic                    r_res_top_valid;
    logic [KEY_BITS-1:0]     r_res_top_key;
    logic [PAYLOAD_BITS-1:0] r_res_top_pay;
    logic [NW-1:0]           r_res_count;

    logic [KEY_BITS-1:0]     w_key_a, w_key_b, w_child_key;
    logic [AW-1:0]           w_parent, w_child_idx;
    logic [CW-1:0]           w_left, w_right, w_n;
    logic                    w_has_l, w_has_r, w_pick_l;
    logic [EW-1:0]           w_child;
    logic                    w_we, w_re_a, w_re_b;
    logic [AW-1:0]           w_waddr, w_raddr_a, w_raddr_b;
    logic [EW-1:0]           w_wdata;

    assign w_key_a  = r_rd_a[EW-1:PAYLOAD_BITS];
    assign w_key_b  = r_rd_b[EW-1:PAYLOAD_BITS];
    assign w_parent = (r_idx - AW'(1)) >> 1;
    assign w_left   = CW'({r_idx, 1'b1});
    assign w_right  = CW'({r_idx, 1'b0}) + CW'(2);
    assign w_n      = CW'(r_count);
    assign w_has_l  = (w_left < w_n);
    assign w_has_r  = (w_right < w_n);

    // left child when there is no right child or it strictly wins over the right one
    assign w_pick_l = !w_has_r ||
                      beats(r_order, KEY_MAX_BITS'(w_key_a), KEY_MAX_BITS'(w_key_b));
    assign w_child     = w_pick_l ? r_rd_a : r_rd_b;
    assign w_child_key = w_pick_l ? w_key_a : w_key_b;
    assign w_child_idx = w_pick_l ? w_left[AW-1:0] : w_right[AW-1:0];

    always_comb begin
        o_stat.is_pop     = r_is_pop;
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = (r_count == NW'(CAPACITY));
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.up_beats   = beats(r_order, KEY_MAX_BITS'(r_x_key), KEY_MAX_BITS'(w_key_a));
        // a tie with the chosen child still swaps
        o_stat.dn_stop    = !w_has_l ||
                            beats(r_order, KEY_MAX_BITS'(r_x_key),
                                  KEY_MAX_BITS'(w_child_key));
    end

    always_comb begin
        w_we      = i_cmd.place || i_cmd.up_move || i_cmd.dn_move;
        w_waddr   = r_idx;
        w_wdata   = {r_x_key, r_x_pay};
        if (i_cmd.up_move) begin
            w_wdata = r_rd_a;
        end else if (i_cmd.dn_move) begin
            w_wdata = w_child;
        end
        w_re_a    = i_cmd.pop_init || i_cmd.up_read || i_cmd.dn_read || i_cmd.top_read;
        w_re_b    = i_cmd.pop_init || i_cmd.dn_read;
        w_raddr_a = '0;
        w_raddr_b = '0;
        if (i_cmd.up_read) begin
            w_raddr_a = w_parent;
        end else if (i_cmd.dn_read) begin
            w_raddr_a = w_left[AW-1:0];
        end
        if (i_cmd.pop_init) begin
            w_raddr_b = AW'(r_count - NW'(1));
        end else if (i_cmd.dn_read) begin
            w_raddr_b = w_right[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re_a) begin
            r_rd_a <= r_mem[w_raddr_a];
        end
        if (w_re_b) begin
            r_rd_b <= r_mem[w_raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_order_max;
            end
            if (i_cmd.pop_init) begin
                r_count <= r_count - NW'(1);
            end else if (i_cmd.place && !r_is_pop) begin
                r_count <= r_count + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_is_pop  <= i_in_command;
            r_x_key   <= i_in_key;
            r_x_pay   <= i_in_payload;
            r_status  <= ST_OK;
            r_pop_key <= '0;
            r_pop_pay <= '0;
        end
        if (i_cmd.set_empty) begin
            r_status <= ST_EMPTY;
        end
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.push_init) begin
            r_idx <= AW'(r_count);
        end
        if (i_cmd.pop_load) begin
            // root leaves, last leaf becomes the moving entry
            r_pop_key <= w_key_a;
            r_pop_pay <= r_rd_a[PAYLOAD_BITS-1:0];
            r_x_key   <= w_key_b;
            r_x_pay   <= r_rd_b[PAYLOAD_BITS-1:0];
            r_idx     <= '0;
        end
        if (i_cmd.up_move) begin
            r_idx <= w_parent;
        end
        if (i_cmd.dn_move) begin
            r_idx <= w_child_idx;
        end
        if (i_cmd.res_load) begin
            r_res_status    <= r_status;
            r_res_pop_key   <= r_pop_key;
            r_res_pop_pay   <= r_pop_pay;
            r_res_top_valid <= (r_count != '0);
            r_res_top_key   <= (r_count != '0) ? w_key_a : '0;
            r_res_top_pay   <= (r_count != '0) ? r_rd_a[PAYLOAD_BITS-1:0] : '0;
            r_res_count     <= r_count;
        end
    end

    assign o_status         = r_res_status;
    assign o_popped_key     = r_res_pop_key;
    assign o_popped_payload = r_res_pop_pay;
    assign o_top_valid      = r_res_top_valid;
    assign o_top_key        = r_res_top_key;
    assign o_top_payload    = r_res_top_pay;
    assign o_entry_count    = r_res_count;

endmodule

// File: hdl/binary_heap_priority_queue_unit.sv
// Flow: a command is latched and dispatched; a flagged one (empty pop, full push) goes on to
// the top read and result load. A push walks up, a pop loads the root and last leaf and walks
// down (at most 10 levels at 1024); then the entry is placed and the result loaded. Each level
// is a registered heap read, then compare/write. One command at a time: the next one is taken
// once the result is registered; a stalled output holds the unit until its register is free.
// Reset: synchronous active low; empties the queue, selects min order, memory not cleared.
`timescale 1ns / 1ps

`include "binary_heap_priority_queue_unit_defines.svh"

module binary_heap_priority_queue_unit
    import bhpq_pkg::*;
#(
    parameter int CAPACITY     = 1024,
    parameter int KEY_BITS     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    bhpq_in_if.sink       i_cmd,
    bhpq_out_if.source    o_res,
    bhpq_cfg_if.sink      i_cfg
);

    localparam int NW = $clog2(CAPACITY + 1);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign i_cfg.ready = 1'b1;

    bhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bhpq_dp #(
        .CAPACITY     (CAPACITY),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_in_command     (i_cmd.command),
        .i_in_key         (i_cmd.key),
        .i_in_payload     (i_cmd.payload),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_order_max  (i_cfg.order_max),
        .o_status         (o_res.status),
        .o_popped_key     (o_res.popped_key),
        .o_popped_payload (o_res.popped_payload),
        .o_top_valid      (o_res.top_valid),
        .o_top_key        (o_res.top_key),
        .o_top_payload    (o_res.top_payload),
        .o_entry_count    (o_res.entry_count)
    );

    `BHPQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, o_res.valid, o_res.entry_count <= NW'(CAPACITY), "entry count above capacity")
    `BHPQ_ASSERT_IMPLY(a_top_matches_count, i_clk, i_rst_n, o_res.valid, o_res.top_valid == (o_res.entry_count != '0), "top valid disagrees with count")
    `BHPQ_ASSERT_IMPLY(a_empty_pop_clean, i_clk, i_rst_n, o_res.valid && o_res.status == ST_EMPTY, o_res.popped_key == '0 && o_res.entry_count == '0, "empty pop reported data")
    `BHPQ_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready, "second word taken while busy")

endmodule

// File: tb/binary_heap_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module binary_heap_priority_queue_unit_tb;

    localparam int CAPACITY      = 1024;
    localparam int KEY_BITS      = 16;
    localparam int PAYLOAD_BITS  = 16;
    localparam int COUNT_BITS    = 11;
    localparam int IDX_BITS      = $clog2(CAPACITY);
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT   = 50;

    typedef enum logic {CMD_PUSH = 1'b0, CMD_POP = 1'b1} t_command;
    typedef enum logic {ORDER_MIN = 1'b0, ORDER_MAX = 1'b1} t_order;

    typedef struct packed {
        logic [1:0]              status;
        logic [KEY_BITS-1:0]     popped_key;
        logic [PAYLOAD_BITS-1:0] popped_payload;
        logic                    top_valid;
        logic [KEY_BITS-1:0]     top_key;
        logic [PAYLOAD_BITS-1:0] top_payload;
        logic [COUNT_BITS-1:0]   entry_count;
    } t_heap_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bhpq_in_if  #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) cmd_if ();
    bhpq_out_if #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS),
                  .COUNT_BITS(COUNT_BITS)) res_if ();
    bhpq_cfg_if cfg_if ();

    binary_heap_priority_queue_unit #(
        .CAPACITY    (CAPACITY),
        .KEY_BITS    (KEY_BITS),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // Shadow queue: its own heap array, fill count and order.
    logic [KEY_BITS-1:0]     heap_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] heap_pay [CAPACITY];
    int unsigned             heap_fill;
    t_order                  heap_order;

    t_heap_result expected_results[$];

    bit idle_on = 1'b1;
    int errors;
    int words_sent;
    int results_seen;
    int empty_pops;
    int quiet_cycles;

    function automatic bit outranks(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
        return (heap_order == ORDER_MAX) ? (a > b) : (a < b);
    endfunction

    function automatic t_heap_result heap_apply(t_command cmd, logic [KEY_BITS-1:0] key,
                                                logic [PAYLOAD_BITS-1:0] pay);
        t_heap_result            r;
        int unsigned             idx, par, lc, rc, pick, last;
        logic [KEY_BITS-1:0]     tk;
        logic [PAYLOAD_BITS-1:0] tp;
        r = '0;
        if (cmd == CMD_PUSH) begin
            if (heap_fill >= CAPACITY) begin
                r.status = bhpq_pkg::ST_FULL;
            end else begin
                // shift parents down until the new key no longer outranks one
                idx = heap_fill;
                while (idx != 0 && outranks(key, heap_key[IDX_BITS'((idx - 1) / 2)])) begin
                    par = (idx - 1) / 2;
                    heap_key[IDX_BITS'(idx)] = heap_key[IDX_BITS'(par)];
                    heap_pay[IDX_BITS'(idx)] = heap_pay[IDX_BITS'(par)];
                    idx = par;
                end
                heap_key[IDX_BITS'(idx)] = key;
                heap_pay[IDX_BITS'(idx)] = pay;
                heap_fill++;
            end
        end else if (heap_fill == 0) begin
            r.status = bhpq_pkg::ST_EMPTY;
        end else begin
            r.popped_key     = heap_key[0];
            r.popped_payload = heap_pay[0];
            heap_fill--;
            last = heap_fill;
            heap_key[0] = heap_key[IDX_BITS'(last)];
            heap_pay[0] = heap_pay[IDX_BITS'(last)];
            idx = 0;
            forever begin
                lc = 2 * idx + 1;
                rc = 2 * idx + 2;
                if (rc < last) begin
                    pick = outranks(heap_key[IDX_BITS'(lc)], heap_key[IDX_BITS'(rc)]) ? lc : rc;
                end else if (lc < last) begin
                    pick = lc;
                end else begin
                    break;
                end
                // a tie still swaps
                if (outranks(heap_key[IDX_BITS'(idx)], heap_key[IDX_BITS'(pick)])) break;
                tk = heap_key[IDX_BITS'(idx)];
                tp = heap_pay[IDX_BITS'(idx)];
                heap_key[IDX_BITS'(idx)]  = heap_key[IDX_BITS'(pick)];
                heap_pay[IDX_BITS'(idx)]  = heap_pay[IDX_BITS'(pick)];
                heap_key[IDX_BITS'(pick)] = tk;
                heap_pay[IDX_BITS'(pick)] = tp;
                idx = pick;
            end
        end
        if (heap_fill > 0) begin
            r.top_valid   = 1'b1;
            r.top_key     = heap_key[0];
            r.top_payload = heap_pay[0];
        end
        r.entry_count = heap_fill[COUNT_BITS-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_LIMIT) $display("[%0t] result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(res_if.status), 32'(want.status));
                check_field("popped_key", 32'(res_if.popped_key), 32'(want.popped_key));
                check_field("popped_payload", 32'(res_if.popped_payload),
                            32'(want.popped_payload));
                check_field("top_valid", 32'(res_if.top_valid), 32'(want.top_valid));
                check_field("top_key", 32'(res_if.top_key), 32'(want.top_key));
                check_field("top_payload", 32'(res_if.top_payload), 32'(want.top_payload));
                check_field("entry_count", 32'(res_if.entry_count), 32'(want.entry_count));
            end
        end
    end

    // Result ready: random stall bursts while idling is on
    initial begin
        int stall;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && stall == 0 && $urandom_range(0, 3) == 0) stall = $urandom_range(1, 5);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_command(t_command cmd, logic [KEY_BITS-1:0] key,
                                logic [PAYLOAD_BITS-1:0] pay);
        t_heap_result r;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= cmd;
        cmd_if.key     <= key;
        cmd_if.payload <= pay;
        do @(posedge i_clk); while (!(cmd_if.valid && cmd_if.ready));
        r = heap_apply(cmd, key, pay);
        expected_results.push_back(r);
        words_sent++;
        if (r.status == bhpq_pkg::ST_EMPTY) empty_pops++;
    endtask

    // Drop valid and hold until every outstanding result is back.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_order(t_order ord);
        wait_drained();
        cfg_if.valid     <= 1'b1;
        cfg_if.order_max <= ord;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        heap_order = ord;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [KEY_BITS-1:0] rand_key(bit narrow);
        if (narrow) return KEY_BITS'($urandom_range(0, 7));
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return KEY_BITS'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] rand_pay();
        return PAYLOAD_BITS'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic test_pop_empty();
        write_order(ORDER_MIN);
        send_command(CMD_POP, 16'hFFFF, 16'hFFFF);
        send_command(CMD_POP, 16'h0000, 16'h0000);
    endtask

    task automatic test_extremes(t_order ord);
        write_order(ord);
        send_command(CMD_PUSH, 16'hFFFF, 16'h0000);
        send_command(CMD_PUSH, 16'h0000, 16'hFFFF);
        send_command(CMD_PUSH, 16'h0000, 16'h5555);
        send_command(CMD_PUSH, 16'hFFFF, 16'hAAAA);
        send_command(CMD_PUSH, 16'h8000, 16'h1234);
        // pop past the last entry
        repeat (6) send_command(CMD_POP, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_order_flip();
        write_order(ORDER_MAX);
        repeat (20) begin
            send_command(CMD_PUSH, rand_key($urandom_range(0, 3) == 0), rand_pay());
        end
        // flip order with entries held; the stored array keeps its shape
        write_order(ORDER_MIN);
        send_command(CMD_POP, 16'h0000, 16'h0000);
        send_command(CMD_PUSH, 16'h0001, 16'hBEEF);
        send_command(CMD_PUSH, 16'h0002, 16'hCAFE);
        while (heap_fill > 0) begin
            send_command(CMD_POP, rand_key(1'b0), rand_pay());
        end
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < 6; phase++) begin
            bit narrow;
            idle_on = (phase != 3 && phase != 5);
            narrow  = (phase == 1 || phase == 4);
            // keep entries across the order change
            write_order((phase % 2 == 1) ? ORDER_MAX : ORDER_MIN);
            for (int n = 0; n < 64; n++) begin
                int push_pct;
                if (phase == 2 && n % 10 == 0) wait_drained();
                if (heap_fill < 4) push_pct = 80;
                else if (heap_fill > 60) push_pct = 30;
                else push_pct = 55;
                if (heap_fill == 0 && $urandom_range(0, 4) == 0) push_pct = 0;
                if ($urandom_range(0, 99) < push_pct) begin
                    send_command(CMD_PUSH, rand_key(narrow), rand_pay());
                end else begin
                    send_command(CMD_POP, rand_key(1'b0), rand_pay());
                end
            end
        end
    endtask

    initial begin
        heap_fill  = 0;
        heap_order = ORDER_MIN;
        i_rst_n          <= 1'b0;
        cmd_if.valid     <= 1'b0;
        cmd_if.command   <= CMD_PUSH;
        cmd_if.key       <= '0;
        cmd_if.payload   <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.order_max <= ORDER_MIN;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_pop_empty();
        test_extremes(ORDER_MIN);
        test_extremes(ORDER_MAX);
        test_order_flip();
        test_random_mix();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d commands in both orders, including %0d pops on an empty queue",
                 words_sent, empty_pops);
        $display("Compared %0d result words, %0d mismatching fields", results_seen, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/bhpq_pkg.sv
hdl/bhpq_if.sv
hdl/bhpq_ctrl.sv
hdl/bhpq_dp.sv
hdl/binary_heap_priority_queue_unit.sv
tb/binary_heap_priority_queue_unit_tb.sv
